[hw/rtl/hks_pkg.sv]
package hks_pkg;

    localparam int ROWS             = 3;
    localparam int MAX_COLUMNS      = 1024;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int KEY_BYTES        = 4;

    localparam int NBUCKETS = ROWS * MAX_COLUMNS;
    localparam int ADDR_W   = (NBUCKETS > 1) ? $clog2(NBUCKETS) : 1;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KB_W     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int COL_W    = 11;
    localparam int CNT_W    = 31;
    localparam int KEY_W    = 32;

    localparam logic [63:0] HASH_SEED = 64'd388650253;
    localparam logic [31:0] HASH_MULT = 32'd388650319;
    localparam logic [63:0] HASH_MIX  = 64'd1176845762;
    localparam logic [CNT_W-1:0] SAT31 = {CNT_W{1'b1}};

    // remainder digits of four bits over the 64-bit hash
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = 64 / MOD_BITS;
    localparam int MC_W      = $clog2(MOD_STEPS);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } slot_t;

    typedef struct packed {
        slot_t [SLOTS_PER_BUCKET-1:0] slots;
        logic  [CNT_W-1:0]            dec;
    } bucket_t;

    localparam int BUCKET_W = $bits(bucket_t);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_KEYH  = 8'b0000_0100,
        ST_ROWH  = 8'b0000_1000,
        ST_MOD   = 8'b0001_0000,
        ST_READ  = 8'b0010_0000,
        ST_UPD   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? SAT31 : s[CNT_W-1:0];
    endfunction

endpackage

[hw/rtl/heavy_key_sketch_with_decrement.sv]
// an insert or query runs from the accepting edge through the key hash, then per row the
// row hash, remainder, read and update states; busy stays high until back in idle, the
// only state that takes a new item; a query alone gives a result beat; kind 3 is dropped
// the remainder unit takes four bits a cycle; each row has one read, and one write on insert
// reset and clear both run a pass over all 3072 buckets, one a cycle, with busy high
// results cannot be stalled: done marks each result beat for exactly one cycle
module heavy_key_sketch_with_decrement
    import hks_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [KEY_W-1:0]  flow_key,
    output logic              done,
    output logic [CNT_W-1:0]  upper_estimate,
    output logic [CNT_W-1:0]  lower_estimate,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              ins_reg, ins_next;
    logic              phase_reg, phase_next;
    logic [KB_W-1:0]   kb_reg, kb_next;
    logic [1:0]        rs_reg, rs_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [MC_W-1:0]   mc_reg, mc_next;
    logic              done_reg, done_next;
    logic [COL_W-1:0]  cols_reg;

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [63:0]       h_reg, h_next;
    logic [63:0]       hk_reg, hk_next;
    logic [63:0]       p_reg, p_next;
    logic [63:0]       dv_reg, dv_next;
    logic [COL_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  up_reg, up_next;
    logic [CNT_W-1:0]  low_reg, low_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [BUCKET_W-1:0] ram_wdata, ram_rdata;

    logic              cfg_wr;
    logic [COL_W-1:0]  cols_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-COL_W){1'b0}}, cols_reg};

    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols_eff = COL_W'(1);
        end
        else if (int'(cols_reg) > MAX_COLUMNS)
        begin
            cols_eff = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = cols_reg;
        end
    end

    // one hash byte step: low partial product first, then high half and the byte
    logic [63:0] key_sh;
    logic [7:0]  hbyte;
    logic [60:0] lo_prod;
    logic [31:0] hi_prod;
    logic [63:0] step_h;

    always_comb
    begin
        key_sh  = {32'd0, key_reg} >> ((KEY_BYTES - 1 - int'(kb_reg)) * 8);
        if (state_reg == ST_KEYH)
        begin
            hbyte = key_sh[7:0];
        end
        else if (rs_reg == 2'd0)
        begin
            hbyte = 8'(row_reg);
        end
        else
        begin
            hbyte = 8'd0;
        end
        lo_prod = 61'(h_reg[31:0]) * 61'(HASH_MULT);
        hi_prod = h_reg[63:32] * HASH_MULT;
        step_h  = p_reg + {hi_prod, 32'd0} + {{56{hbyte[7]}}, hbyte};
    end

    // four restoring remainder steps per cycle
    logic [COL_W-1:0] rem_step;
    logic [COL_W:0]   rtmp;

    always_comb
    begin
        rem_step = rem_reg;
        rtmp     = '0;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            rtmp = {rem_step, dv_reg[63-i]};
            if (rtmp >= {1'b0, cols_eff})
            begin
                rtmp = rtmp - {1'b0, cols_eff};
            end
            rem_step = rtmp[COL_W-1:0];
        end
    end

    // bucket read-modify-write
    bucket_t          bk, nb;
    logic             hit, has_free;
    logic [CNT_W-1:0] hit_cnt, mn, cur_up;

    always_comb
    begin
        bk       = bucket_t'(ram_rdata);
        nb       = bk;
        hit      = 1'b0;
        has_free = 1'b0;
        hit_cnt  = '0;
        mn       = SAT31;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (!hit && bk.slots[s].valid && bk.slots[s].key == key_reg)
            begin
                hit     = 1'b1;
                hit_cnt = bk.slots[s].count;
                nb.slots[s].count = sat_add(bk.slots[s].count, CNT_W'(1));
            end
            if (bk.slots[s].count < mn)
            begin
                mn = bk.slots[s].count;
            end
        end
        if (!hit)
        begin
            for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            begin
                if (!has_free && !bk.slots[s].valid)
                begin
                    has_free = 1'b1;
                    nb.slots[s].valid = 1'b1;
                    nb.slots[s].key   = key_reg;
                    nb.slots[s].count = CNT_W'(1);
                end
            end
            if (!has_free)
            begin
                nb.dec = sat_add(bk.dec, mn);
                for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                begin
                    nb.slots[s].count = bk.slots[s].count - mn;
                    nb.slots[s].valid = (bk.slots[s].count != mn);
                end
            end
        end
        cur_up = hit ? sat_add(hit_cnt, bk.dec) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ins_next   = ins_reg;
        phase_next = phase_reg;
        kb_next    = kb_reg;
        rs_next    = rs_reg;
        row_next   = row_reg;
        mc_next    = mc_reg;
        done_next  = 1'b0;
        key_next   = key_reg;
        h_next     = h_reg;
        hk_next    = hk_reg;
        p_next     = p_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        up_next    = up_reg;
        low_next   = low_reg;
        ram_we     = 1'b0;
        ram_addr   = addr_reg;
        ram_wdata  = BUCKET_W'(nb);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (int'(clr_reg) == NBUCKETS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = flow_key;
                    ins_next   = (kind == KIND_INSERT);
                    h_next     = HASH_SEED;
                    phase_next = 1'b0;
                    kb_next    = '0;
                    up_next    = SAT31;
                    low_next   = '0;
                    if (kind == KIND_CLEAR)
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (kind == KIND_INSERT || kind == KIND_QUERY)
                    begin
                        state_next = ST_KEYH;
                    end
                end
            end
            ST_KEYH:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    p_next = 64'(lo_prod);
                end
                else
                begin
                    h_next  = step_h;
                    kb_next = kb_reg + KB_W'(1);
                    if (int'(kb_reg) == KEY_BYTES - 1)
                    begin
                        hk_next    = step_h;
                        row_next   = '0;
                        rs_next    = '0;
                        state_next = ST_ROWH;
                    end
                end
            end
            ST_ROWH:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    p_next = 64'(lo_prod);
                end
                else
                begin
                    h_next  = step_h;
                    rs_next = rs_reg + 2'd1;
                    if (rs_reg == 2'd3)
                    begin
                        dv_next    = step_h ^ HASH_MIX;
                        rem_next   = '0;
                        mc_next    = '0;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next = rem_step;
                dv_next  = dv_reg << MOD_BITS;
                mc_next  = mc_reg + MC_W'(1);
                if (int'(mc_reg) == MOD_STEPS - 1)
                begin
                    addr_next  = ADDR_W'(int'(row_reg) * MAX_COLUMNS + int'(rem_step));
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (ins_reg)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    if (cur_up < up_reg)
                    begin
                        up_next = cur_up;
                    end
                    if (hit && hit_cnt > low_reg)
                    begin
                        low_next = hit_cnt;
                    end
                end
                row_next   = row_reg + ROW_W'(1);
                h_next     = hk_reg;
                rs_next    = '0;
                phase_next = 1'b0;
                if (int'(row_reg) == ROWS - 1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ROWH;
                end
            end
            ST_DONE:
            begin
                done_next  = !ins_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ins_reg   <= 1'b0;
            phase_reg <= 1'b0;
            kb_reg    <= '0;
            rs_reg    <= '0;
            row_reg   <= '0;
            mc_reg    <= '0;
            done_reg  <= 1'b0;
            cols_reg  <= COL_W'(1024);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ins_reg   <= ins_next;
            phase_reg <= phase_next;
            kb_reg    <= kb_next;
            rs_reg    <= rs_next;
            row_reg   <= row_next;
            mc_reg    <= mc_next;
            done_reg  <= done_next;
            if (cfg_wr)
            begin
                cols_reg <= pwdata[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        h_reg    <= h_next;
        hk_reg   <= hk_next;
        p_reg    <= p_next;
        dv_reg   <= dv_next;
        rem_reg  <= rem_next;
        addr_reg <= addr_next;
        up_reg   <= up_next;
        low_reg  <= low_next;
    end

    hks_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (NBUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign upper_estimate = up_reg;
    assign lower_estimate = low_reg;

endmodule

[hw/rtl/hks_ram.sv]
module hks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[bench/tb_heavy_key_sketch_with_decrement.sv]
`timescale 1ns / 100ps

module tb_heavy_key_sketch_with_decrement;
    import hks_pkg::*;

    localparam int NSLOT       = NBUCKETS * SLOTS_PER_BUCKET;
    localparam int DRAIN_WAIT  = 8 + 27 * ROWS + 20;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [2:0] ADDR_COLUMNS = 3'd0;
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef struct {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
    } sketch_op_t;

    typedef struct {
        logic [CNT_W-1:0] up;
        logic [CNT_W-1:0] low;
    } estimate_t;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic [1:0] kind = KIND_INSERT;
    logic [KEY_W-1:0] flow_key = '0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic busy, done, pready;
    logic [CNT_W-1:0] upper_estimate, lower_estimate;
    logic [31:0] prdata;

    sketch_op_t pending_ops[$];
    estimate_t  estimates_due[$];
    int unsigned idle_pct = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    logic [KEY_W-1:0] key_pool[12];

    // shadow copy of the sketch
    logic [KEY_W-1:0] sh_key[NSLOT];
    logic [CNT_W-1:0] sh_count[NSLOT];
    logic             sh_valid[NSLOT];
    logic [CNT_W-1:0] sh_dec[NBUCKETS];
    logic [10:0]      sh_columns = 11'd1024;

    heavy_key_sketch_with_decrement u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .flow_key(flow_key), .done(done), .upper_estimate(upper_estimate),
        .lower_estimate(lower_estimate), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #1 clk = ~clk;

    function automatic logic [CNT_W-1:0] add_sat(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic int bucket_of(logic [KEY_W-1:0] key, int row);
        logic [63:0] h;
        logic [7:0]  b;
        logic [31:0] r;
        int          cols;
        cols = sh_columns;
        if (cols == 0) cols = 1;
        if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
        r = row;
        h = 64'd388650253;
        for (int i = 0; i < 4; i++)
        begin
            b = key[8*(3-i) +: 8];
            h = h * 64'd388650319 + {{56{b[7]}}, b};
        end
        for (int i = 0; i < 4; i++)
        begin
            b = r[8*i +: 8];
            h = h * 64'd388650319 + {{56{b[7]}}, b};
        end
        h ^= 64'd1176845762;
        return row * MAX_COLUMNS + int'(h % cols);
    endfunction

    task automatic insert_row(logic [KEY_W-1:0] key, int row);
        int bk, base, free_s;
        logic [CNT_W-1:0] m;
        bk = bucket_of(key, row);
        base = bk * SLOTS_PER_BUCKET;
        free_s = -1;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            if (sh_valid[base+s] && sh_key[base+s] == key)
            begin
                sh_count[base+s] = add_sat(sh_count[base+s], CNT_W'(1));
                return;
            end
            if (!sh_valid[base+s] && free_s < 0) free_s = s;
        end
        if (free_s >= 0)
        begin
            sh_valid[base+free_s] = 1'b1;
            sh_key[base+free_s] = key;
            sh_count[base+free_s] = CNT_W'(1);
            return;
        end
        // full bucket: shave the smallest count off everyone
        m = {CNT_W{1'b1}};
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            if (sh_count[base+s] < m) m = sh_count[base+s];
        sh_dec[bk] = add_sat(sh_dec[bk], m);
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            sh_count[base+s] -= m;
            if (sh_count[base+s] == '0) sh_valid[base+s] = 1'b0;
        end
    endtask

    task automatic apply_op(logic [1:0] k, logic [KEY_W-1:0] key);
        estimate_t e;
        logic [CNT_W-1:0] cur;
        int bk, base;
        if (k == KIND_INSERT)
        begin
            for (int r = 0; r < ROWS; r++) insert_row(key, r);
        end
        else if (k == KIND_CLEAR)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                sh_valid[i] = 1'b0;
                sh_count[i] = '0;
            end
            for (int i = 0; i < NBUCKETS; i++) sh_dec[i] = '0;
        end
        else if (k == KIND_QUERY)
        begin
            e.up = {CNT_W{1'b1}};
            e.low = '0;
            for (int r = 0; r < ROWS; r++)
            begin
                bk = bucket_of(key, r);
                base = bk * SLOTS_PER_BUCKET;
                cur = '0;
                for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                    if (sh_valid[base+s] && sh_key[base+s] == key)
                    begin
                        cur = add_sat(sh_count[base+s], sh_dec[bk]);
                        if (sh_count[base+s] > e.low) e.low = sh_count[base+s];
                        break;
                    end
                if (cur < e.up) e.up = cur;
            end
            estimates_due.push_back(e);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drv
        sketch_op_t nxt;
        bit taken;
        if (!rst_n)
        begin
            start <= 0;
        end
        else
        begin
            taken = start && !busy;
            if (taken) apply_op(kind, flow_key);
            if (!start || taken)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = pending_ops.pop_front();
                    start <= 1;
                    kind <= nxt.kind;
                    flow_key <= nxt.key;
                end
                else
                    start <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : mon
        estimate_t e;
        if (rst_n && done)
        begin
            if (estimates_due.size() == 0)
            begin
                $display("%0t: unexpected result beat up=%0d low=%0d", $time,
                         upper_estimate, lower_estimate);
                errors++;
            end
            else
            begin
                e = estimates_due.pop_front();
                if (upper_estimate !== e.up)
                begin
                    $display("%0t: upper_estimate expected %0d got %0d", $time, e.up,
                             upper_estimate);
                    errors++;
                end
                if (lower_estimate !== e.low)
                begin
                    $display("%0t: lower_estimate expected %0d got %0d", $time, e.low,
                             lower_estimate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_op(logic [1:0] k, logic [KEY_W-1:0] key);
        sketch_op_t o;
        o.kind = k;
        o.key = key;
        pending_ops.push_back(o);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == ADDR_COLUMNS) sh_columns = data[10:0];
        @(posedge clk);
        if (addr == ADDR_COLUMNS && prdata !== {21'd0, data[10:0]})
        begin
            $display("%0t: columns_in_use readback expected %0d got %0d", $time,
                     data[10:0], prdata);
            errors++;
        end
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || start || estimates_due.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic new_pool();
        foreach (key_pool[i]) key_pool[i] = $urandom;
    endtask

    task automatic random_ops(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55) push_op(KIND_INSERT, key_pool[$urandom_range(0, 11)]);
            else if (r < 85) push_op(KIND_QUERY, key_pool[$urandom_range(0, 11)]);
            else if (r < 92) push_op(KIND_QUERY, $urandom);
            else if (r < 97) push_op(KIND_INSERT, $urandom);
            else if (r < 99) push_op(KIND_NONE, $urandom);
            else push_op(KIND_CLEAR, $urandom);
        end
    endtask

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_count[i] = '0;
            sh_key[i] = '0;
        end
        for (int i = 0; i < NBUCKETS; i++) sh_dec[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);

        // default columns, field extremes
        idle_pct = 0;
        push_op(KIND_INSERT, 32'h0000_0000);
        push_op(KIND_INSERT, 32'hFFFF_FFFF);
        push_op(KIND_INSERT, 32'h8080_8080);
        push_op(KIND_INSERT, 32'hFFFF_FFFF);
        push_op(KIND_QUERY, 32'h0000_0000);
        push_op(KIND_QUERY, 32'hFFFF_FFFF);
        push_op(KIND_QUERY, 32'h8080_8080);
        push_op(KIND_QUERY, 32'h7F7F_7F7F);
        push_op(KIND_NONE, 32'h1234_5678);
        push_op(KIND_CLEAR, 32'h0);
        push_op(KIND_QUERY, 32'hFFFF_FFFF);
        drain();

        // single column: full buckets force decrements
        reg_write(ADDR_COLUMNS, 32'd1);
        for (int i = 0; i < 4; i++) push_op(KIND_INSERT, 32'hA000_0000 + i);
        push_op(KIND_INSERT, 32'hA000_0000);
        push_op(KIND_INSERT, 32'hB000_0005);
        push_op(KIND_QUERY, 32'hA000_0000);
        push_op(KIND_QUERY, 32'hA000_0001);
        push_op(KIND_QUERY, 32'hB000_0005);
        push_op(KIND_INSERT, 32'hB000_0006);
        push_op(KIND_QUERY, 32'hA000_0000);
        drain();

        // zero columns behaves as one, store kept across the change
        reg_write(ADDR_COLUMNS, 32'd0);
        idle_pct = 72;
        new_pool();
        random_ops(120);
        drain();

        reg_write(ADDR_COLUMNS, 32'h7FF);
        idle_pct = 16;
        random_ops(120);
        drain();

        reg_write(ADDR_COLUMNS, $urandom_range(2, 8));
        reg_write(ADDR_UNUSED, 32'd5);
        idle_pct = 72;
        new_pool();
        random_ops(150);
        drain();

        reg_write(ADDR_COLUMNS, 32'd1024);
        idle_pct = 0;
        random_ops(40);
        drain();

        reg_write(ADDR_COLUMNS, 32'd3);
        random_ops(120);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[heavy_key_sketch_with_decrement.f]
hw/rtl/hks_pkg.sv
hw/rtl/hks_ram.sv
hw/rtl/heavy_key_sketch_with_decrement.sv
bench/tb_heavy_key_sketch_with_decrement.sv
